>>> hw/rtl/bct_pkg.sv
// Shared types and constants of the barometric compensation core.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package bct_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_CALIB_TEMP = 2'd0;
    localparam logic [1:0] REG_PRESS_LOW  = 2'd1;
    localparam logic [1:0] REG_PRESS_HIGH = 2'd2;
    localparam logic [1:0] REG_PRESS_LAST = 2'd3;

    // Fine temperature saturation bounds and pressure offset.
    localparam logic signed [21:0] FINE_MAX    = 22'sd1048575;
    localparam logic signed [21:0] FINE_MIN    = -22'sd1048576;
    localparam logic signed [21:0] FINE_OFFSET = 22'sd128000;

    // One quotient bit is resolved per divider stage.
    localparam int DIV_BITS = 64;

    // Decoded calibration words.
    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } calib_t;

    // Fields that ride alongside the pressure datapath.
    typedef struct packed {
        logic signed [20:0] fine;
        logic signed [19:0] centi;
        logic               bad;
    } side_t;

endpackage

>>> hw/rtl/bct_temp.sv
// Temperature compensation pipeline: four register stages, 32-bit wrapping math.
// Depends on bct_pkg.
`timescale 1ns / 1ps

module bct_temp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [19:0]         raw_temp,
    input  logic [19:0]         raw_press,
    input  bct_pkg::calib_t     calib,
    output logic                out_valid,
    output logic signed [20:0]  fine,
    output logic signed [19:0]  centi,
    output logic [19:0]         press
);

    logic [3:0] valid_reg;

    logic signed [17:0] diff_a;
    logic signed [16:0] diff_d;
    logic signed [33:0] a_prod_next, a_prod_reg;
    logic signed [33:0] dsq_next, dsq_reg;
    logic [19:0]        rp_a_reg, rp_b_reg, rp_c_reg, rp_d_reg;

    logic signed [31:0] a_wrap, a_shift, d_wrap, d_shift;
    logic signed [19:0] b1;
    logic signed [20:0] a_sh_next, a_sh_reg;
    logic signed [35:0] b_prod_next, b_prod_reg;

    logic signed [31:0] b_wrap, b_shift;
    logic signed [21:0] sum;
    logic signed [20:0] fine_next, fine_c_reg, fine_d_reg;

    logic signed [23:0] f24, x24, c24;
    logic signed [19:0] centi_next, centi_reg;

    always_comb begin
        diff_a      = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
        diff_d      = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, calib.t1});
        a_prod_next = diff_a * $signed(calib.t2);
        dsq_next    = diff_d * diff_d;
    end

    always_comb begin
        a_wrap      = $signed(a_prod_reg[31:0]);
        a_shift     = a_wrap >>> 11;
        a_sh_next   = a_shift[20:0];
        d_wrap      = $signed(dsq_reg[31:0]);
        d_shift     = d_wrap >>> 12;
        b1          = d_shift[19:0];
        b_prod_next = b1 * $signed(calib.t3);
    end

    always_comb begin
        b_wrap  = $signed(b_prod_reg[31:0]);
        b_shift = b_wrap >>> 14;
        sum     = $signed({a_sh_reg[20], a_sh_reg}) + $signed(b_shift[21:0]);
        priority if (sum > bct_pkg::FINE_MAX) begin
            fine_next = bct_pkg::FINE_MAX[20:0];
        end else if (sum < bct_pkg::FINE_MIN) begin
            fine_next = bct_pkg::FINE_MIN[20:0];
        end else begin
            fine_next = sum[20:0];
        end
    end

    // Times five is a shift and an add; the constant rounds before the shift.
    always_comb begin
        f24        = {{3{fine_c_reg[20]}}, fine_c_reg};
        x24        = (f24 <<< 2) + f24 + 24'sd128;
        c24        = x24 >>> 8;
        centi_next = c24[19:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_prod_reg <= a_prod_next;
            dsq_reg    <= dsq_next;
            rp_a_reg   <= raw_press;
            a_sh_reg   <= a_sh_next;
            b_prod_reg <= b_prod_next;
            rp_b_reg   <= rp_a_reg;
            fine_c_reg <= fine_next;
            rp_c_reg   <= rp_b_reg;
            fine_d_reg <= fine_c_reg;
            centi_reg  <= centi_next;
            rp_d_reg   <= rp_c_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign fine      = fine_d_reg;
    assign centi     = centi_reg;
    assign press     = rp_d_reg;

endmodule

>>> hw/rtl/bct_pvar.sv
// Pressure variable pipeline: six stages that form the divider's operands.
// Depends on bct_pkg.
`timescale 1ns / 1ps

module bct_pvar (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [20:0]  fine,
    input  logic signed [19:0]  centi,
    input  logic [19:0]         raw_press,
    input  bct_pkg::calib_t     calib,
    output logic                out_valid,
    output logic [63:0]         num_mag,
    output logic [30:0]         den_mag,
    output logic                neg,
    output bct_pkg::side_t      side
);

    logic [5:0] valid_reg;

    // Sideband delay line for fine, centi and the raw pressure.
    logic signed [20:0] fine_reg  [6];
    logic signed [19:0] centi_reg [6];
    logic [19:0]        rp_reg    [2];

    // Stage 1
    logic signed [21:0] v1;
    logic signed [43:0] sq_next, sq_reg;
    logic signed [37:0] m5_next, m5_reg, m5_b_reg;
    logic signed [37:0] m2_next, m2_reg, m2_b_reg;
    // Stage 2
    logic signed [59:0] x6_next, x6_reg, x3_next, x3_reg;
    // Stage 3
    logic signed [59:0] x3_shift;
    logic [59:0]        v2_next, v2_reg;
    logic [51:0]        w_next, w_reg;
    logic [20:0]        pn_next, pn_reg;
    // Stage 4
    logic [63:0]        diffn_next, diffn_reg;
    logic [41:0]        ml_next, ml_reg;
    logic signed [42:0] mh_next, mh_reg;
    // Stage 5
    logic [63:0]        prod;
    logic [63:0]        num_next, num_reg;
    logic [30:0]        den_next, den_reg;
    // Stage 6
    logic [63:0]        num_mag_reg;
    logic [30:0]        den_mag_reg;
    logic               neg_reg, bad_reg;

    always_comb begin
        v1      = $signed({fine[20], fine}) - bct_pkg::FINE_OFFSET;
        sq_next = v1 * v1;
        m5_next = v1 * $signed(calib.p5);
        m2_next = v1 * $signed(calib.p2);
    end

    always_comb begin
        x6_next = sq_reg * $signed(calib.p6);
        x3_next = sq_reg * $signed(calib.p3);
    end

    // These sums stay well inside their widths for every input.
    always_comb begin
        x3_shift = x3_reg >>> 8;
        v2_next  = x6_reg + {{5{m5_b_reg[37]}}, m5_b_reg, 17'b0}
                 + {{9{calib.p4[15]}}, calib.p4, 35'b0};
        w_next   = x3_shift[51:0] + {{2{m2_b_reg[37]}}, m2_b_reg, 12'b0}
                 + {4'b0, 1'b1, 47'b0};
        pn_next  = 21'h10_0000 - {1'b0, rp_reg[1]};
    end

    always_comb begin
        diffn_next = {12'b0, pn_reg, 31'b0} - {{4{v2_reg[59]}}, v2_reg};
        ml_next    = w_reg[25:0] * calib.p1;
        mh_next    = $signed(w_reg[51:26]) * $signed({1'b0, calib.p1});
    end

    // The 64-bit product wraps; the divisor is its top 31 bits.
    always_comb begin
        prod     = {mh_reg[37:0], 26'b0} + {22'b0, ml_reg};
        den_next = prod[63:33];
        num_next = diffn_reg * 64'd3125;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fine_reg[0]  <= fine;
            centi_reg[0] <= centi;
            for (int i = 1; i < 6; i++) begin
                fine_reg[i]  <= fine_reg[i-1];
                centi_reg[i] <= centi_reg[i-1];
            end
            rp_reg[0] <= raw_press;
            rp_reg[1] <= rp_reg[0];

            sq_reg    <= sq_next;
            m5_reg    <= m5_next;
            m2_reg    <= m2_next;
            x6_reg    <= x6_next;
            x3_reg    <= x3_next;
            m5_b_reg  <= m5_reg;
            m2_b_reg  <= m2_reg;
            v2_reg    <= v2_next;
            w_reg     <= w_next;
            pn_reg    <= pn_next;
            diffn_reg <= diffn_next;
            ml_reg    <= ml_next;
            mh_reg    <= mh_next;
            num_reg   <= num_next;
            den_reg   <= den_next;

            bad_reg     <= (den_reg == 31'd0);
            neg_reg     <= num_reg[63] ^ den_reg[30];
            num_mag_reg <= num_reg[63] ? (64'd0 - num_reg) : num_reg;
            den_mag_reg <= den_reg[30] ? (31'd0 - den_reg) : den_reg;
        end
    end

    // The sideband delay line is as deep as the six operand stages.
    assign out_valid  = valid_reg[5];
    assign num_mag    = num_mag_reg;
    assign den_mag    = den_mag_reg;
    assign neg        = neg_reg;
    assign side.fine  = fine_reg[5];
    assign side.centi = centi_reg[5];
    assign side.bad   = bad_reg;

endmodule

>>> hw/rtl/bct_div.sv
// Pipelined restoring divider: one quotient bit per stage, unsigned magnitudes.
// Depends on bct_pkg.
`timescale 1ns / 1ps

module bct_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [63:0]     num_mag,
    input  logic [30:0]     den_mag,
    input  logic            in_neg,
    input  bct_pkg::side_t  in_side,
    output logic            out_valid,
    output logic [63:0]     quo_mag,
    output logic            out_neg,
    output bct_pkg::side_t  out_side
);

    localparam int N = bct_pkg::DIV_BITS;

    // Each word shifts dividend bits out of the top and quotient bits in at the bottom.
    logic [N-1:0]   valid_reg;
    logic [63:0]    word_reg [N];
    logic [30:0]    rem_reg  [N];
    logic [30:0]    den_reg  [N];
    logic           neg_reg  [N];
    bct_pkg::side_t side_reg [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic [63:0]    word_in;
            logic [30:0]    rem_in, den_in;
            logic           neg_in;
            bct_pkg::side_t side_in;
            logic [31:0]    trial, diff;
            logic           ge;
            logic [63:0]    word_next;
            logic [30:0]    rem_next;

            if (k == 0) begin : g_first
                assign word_in = num_mag;
                assign rem_in  = '0;
                assign den_in  = den_mag;
                assign neg_in  = in_neg;
                assign side_in = in_side;
            end else begin : g_rest
                assign word_in = word_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign den_in  = den_reg[k-1];
                assign neg_in  = neg_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            always_comb begin
                trial     = {rem_in, word_in[63]};
                diff      = trial - {1'b0, den_in};
                ge        = (trial >= {1'b0, den_in});
                rem_next  = ge ? diff[30:0] : trial[30:0];
                word_next = {word_in[62:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    word_reg[k] <= word_next;
                    rem_reg[k]  <= rem_next;
                    den_reg[k]  <= den_in;
                    neg_reg[k]  <= neg_in;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quo_mag   = word_reg[N-1];
    assign out_neg   = neg_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

>>> hw/rtl/bct_post.sv
// Pressure refinement pipeline: sign fix, quadratic and linear corrections, Q24.8 output.
// Depends on bct_pkg; 64-bit wrapping products are built from 32-bit partials.
`timescale 1ns / 1ps

module bct_post (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [63:0]         quo_mag,
    input  logic                neg,
    input  bct_pkg::side_t      side,
    input  bct_pkg::calib_t     calib,
    output logic                out_valid,
    output logic signed [20:0]  fine,
    output logic signed [19:0]  centi,
    output logic [31:0]         press,
    output logic                invalid
);

    logic [5:0] valid_reg;
    bct_pkg::side_t side_reg [6];
    logic [63:0] p_reg [4];

    // Stage 2
    logic [63:0]        q;
    logic [63:0]        ll_next, ll_reg;
    logic [31:0]        lh_next, lh_reg;
    logic signed [48:0] pl8_next, pl8_reg;
    logic [31:0]        ph8_next, ph8_reg;
    // Stage 3
    logic [63:0]        r_next, r_reg, t8_next, t8_reg, t8_d_reg;
    // Stage 4
    logic signed [48:0] l9_next, l9_reg;
    logic [31:0]        h9_next, h9_reg;
    // Stage 5
    logic [63:0]        t9, sh9, sh8;
    logic [63:0]        sum_next, sum_reg;
    // Stage 6
    logic [63:0]        sum_shift;
    logic [31:0]        press_next, press_reg;

    always_comb begin
        q        = $signed(p_reg[0]) >>> 13;
        ll_next  = q[31:0] * q[31:0];
        lh_next  = q[31:0] * q[63:32];
        pl8_next = $signed({1'b0, p_reg[0][31:0]}) * $signed(calib.p8);
        ph8_next = p_reg[0][63:32] * {{16{calib.p8[15]}}, calib.p8};
    end

    // Square modulo 2^64: the cross term counts twice.
    always_comb begin
        r_next  = ll_reg + {lh_reg[30:0], 1'b0, 32'b0};
        t8_next = {{15{pl8_reg[48]}}, pl8_reg} + {ph8_reg, 32'b0};
    end

    always_comb begin
        l9_next = $signed({1'b0, r_reg[31:0]}) * $signed(calib.p9);
        h9_next = r_reg[63:32] * {{16{calib.p9[15]}}, calib.p9};
    end

    always_comb begin
        t9       = {{15{l9_reg[48]}}, l9_reg} + {h9_reg, 32'b0};
        sh9      = $signed(t9) >>> 25;
        sh8      = $signed(t8_d_reg) >>> 19;
        sum_next = p_reg[3] + sh9 + sh8;
    end

    always_comb begin
        sum_shift  = $signed(sum_reg) >>> 8;
        press_next = sum_shift[31:0] + {{12{calib.p7[15]}}, calib.p7, 4'b0};
        if (side_reg[4].bad) begin
            press_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side;
            for (int i = 1; i < 6; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            p_reg[0] <= neg ? (64'd0 - quo_mag) : quo_mag;
            for (int i = 1; i < 4; i++) begin
                p_reg[i] <= p_reg[i-1];
            end
            ll_reg    <= ll_next;
            lh_reg    <= lh_next;
            pl8_reg   <= pl8_next;
            ph8_reg   <= ph8_next;
            r_reg     <= r_next;
            t8_reg    <= t8_next;
            l9_reg    <= l9_next;
            h9_reg    <= h9_next;
            t8_d_reg  <= t8_reg;
            sum_reg   <= sum_next;
            press_reg <= press_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign fine      = side_reg[5].fine;
    assign centi     = side_reg[5].centi;
    assign invalid   = side_reg[5].bad;
    assign press     = press_reg;

endmodule

>>> hw/rtl/baro_temp_compensation_core.sv
// Barometric temperature and pressure compensation core, top level.
// Pipeline of 4 temperature, 6 pressure setup, 64 divider and 6 refinement stages.
// Throughput: one word per cycle unless a result word waits on m_tready.
// The whole pipeline holds while a result word waits on m_tready.
// Synchronous active-low reset clears all valid bits and the calibration registers.
`timescale 1ns / 1ps

module baro_temp_compensation_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temp [19:0], raw_press [39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // fine_temp [20:0], temp_centi [40:21],
                                   // press_q24_8 [72:41], zero fill [79:73]
    output logic        m_tuser    // press_invalid
);

    logic [47:0] calib_temp_reg;
    logic [63:0] press_low_reg, press_high_reg;
    logic [15:0] press_last_reg;
    bct_pkg::calib_t calib;

    logic en;

    logic               t_valid;
    logic signed [20:0] t_fine;
    logic signed [19:0] t_centi;
    logic [19:0]        t_press;

    logic               v_valid;
    logic [63:0]        v_num;
    logic [30:0]        v_den;
    logic               v_neg;
    bct_pkg::side_t     v_side;

    logic               d_valid;
    logic [63:0]        d_quo;
    logic               d_neg;
    bct_pkg::side_t     d_side;

    logic               o_valid;
    logic signed [20:0] o_fine;
    logic signed [19:0] o_centi;
    logic [31:0]        o_press;
    logic               o_invalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_temp_reg <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_last_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bct_pkg::REG_CALIB_TEMP: calib_temp_reg <= cfg_wdata[47:0];
                bct_pkg::REG_PRESS_LOW:  press_low_reg  <= cfg_wdata;
                bct_pkg::REG_PRESS_HIGH: press_high_reg <= cfg_wdata;
                bct_pkg::REG_PRESS_LAST: press_last_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        calib.t1 = calib_temp_reg[15:0];
        calib.t2 = calib_temp_reg[31:16];
        calib.t3 = calib_temp_reg[47:32];
        calib.p1 = press_low_reg[15:0];
        calib.p2 = press_low_reg[31:16];
        calib.p3 = press_low_reg[47:32];
        calib.p4 = press_low_reg[63:48];
        calib.p5 = press_high_reg[15:0];
        calib.p6 = press_high_reg[31:16];
        calib.p7 = press_high_reg[47:32];
        calib.p8 = press_high_reg[63:48];
        calib.p9 = press_last_reg;
    end

    // Every stage advances together unless the output word is held.
    assign en       = !o_valid || m_tready;
    assign s_tready = en;

    bct_temp u_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .raw_temp  (s_tdata[19:0]),
        .raw_press (s_tdata[39:20]),
        .calib     (calib),
        .out_valid (t_valid),
        .fine      (t_fine),
        .centi     (t_centi),
        .press     (t_press)
    );

    bct_pvar u_pvar (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t_valid),
        .fine      (t_fine),
        .centi     (t_centi),
        .raw_press (t_press),
        .calib     (calib),
        .out_valid (v_valid),
        .num_mag   (v_num),
        .den_mag   (v_den),
        .neg       (v_neg),
        .side      (v_side)
    );

    bct_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_valid),
        .num_mag   (v_num),
        .den_mag   (v_den),
        .in_neg    (v_neg),
        .in_side   (v_side),
        .out_valid (d_valid),
        .quo_mag   (d_quo),
        .out_neg   (d_neg),
        .out_side  (d_side)
    );

    bct_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .quo_mag   (d_quo),
        .neg       (d_neg),
        .side      (d_side),
        .calib     (calib),
        .out_valid (o_valid),
        .fine      (o_fine),
        .centi     (o_centi),
        .press     (o_press),
        .invalid   (o_invalid)
    );

    assign m_tvalid = o_valid;
    assign m_tdata  = {7'b0, o_press, o_centi, o_fine};
    assign m_tuser  = o_invalid;

    // A zero divisor must force the pressure to zero.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[72:41] == 32'd0)
        else $error("pressure not zero on invalid word");

    // The centi value must match the fine value that traveled with it.
    a_centi_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[40:21]
            == 20'(($signed(m_tdata[20:0]) * 5 + 128) >>> 8))
        else $error("temp_centi out of step with fine_temp");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

endmodule
